### design/appm_pkg.sv
// Shared types and constants for the adaptive peak pulse rate meter.
package appm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FLOOR_W    = 15;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned PEAK_W     = 32;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned PROD_W     = PEAK_W + DECAY_W;

  localparam logic [DECAY_W-1:0] DECAY_NUM = 16'd64881;
  localparam logic [SUM_W-1:0]   RATE_NUM  = 20'd60000;
  localparam logic [RATE_W-1:0]  RATE_MAX  = 8'd255;

  localparam logic [FLOOR_W-1:0] FLOOR_RST   = 15'd300;
  localparam logic [CNT_W-1:0]   MIN_IV_RST  = 16'd300;
  localparam logic [CNT_W-1:0]   MAX_IV_RST  = 16'd2000;
  localparam logic [CNT_W-1:0]   TIMEOUT_RST = 16'd2000;
  localparam logic [CNT_W-1:0]   PERIOD_RST  = 16'd10000;
  localparam logic [RATE_W-1:0]  RATE_RST    = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR   = 3'd0,
    CFG_MIN_IV  = 3'd1,
    CFG_MAX_IV  = 3'd2,
    CFG_TIMEOUT = 3'd3,
    CFG_PERIOD  = 3'd4
  } cfg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_THR   = 9'b000000100,
    ST_CMP   = 9'b000001000,
    ST_STORE = 9'b000010000,
    ST_PER   = 9'b000100000,
    ST_DIV1  = 9'b001000000,
    ST_DIV2  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } appm_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic thr;
    logic cmp;
    logic store;
    logic period_clr;
    logic rate_zero;
    logic div_start;
    logic div_second;
    logic rate_div;
    logic out_load;
  } appm_cmd_t;

  typedef struct packed {
    logic report_due;
    logic ring_empty;
    logic div_done;
    logic div_zero;
  } appm_stat_t;

endpackage

### design/appm_in_if.sv
// Sample input channel: valid/ready handshake with one signed sample.
interface appm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### design/appm_out_if.sv
// Result output channel: valid/ready handshake with pulse flag, rate and count.
interface appm_out_if;
  logic        valid;
  logic        ready;
  logic        pulse_found;
  logic [7:0]  rate_bpm;
  logic [15:0] pulse_total;

  modport source (output valid, output pulse_found, output rate_bpm, output pulse_total,
                  input ready);
  modport sink   (input valid, input pulse_found, input rate_bpm, input pulse_total,
                  output ready);
endinterface

### design/adaptive_peak_pulse_rate_meter_unit.sv
// Top level of the adaptive peak pulse rate meter.
//
//   channel  dir  handshake            payload
//   smp_i    in   valid/ready          sample (SAMPLE_BITS, signed)
//   res_o    out  valid/ready          pulse_found, rate_bpm, pulse_total
//   cfg      in   cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// From accept to the next accept an item steps through multiply, thresholds,
// compare, ring update and period check, each in its own state.
// A report item with a non-empty ring runs the 20-bit serial divider once for the
// mean interval, then for 60000 over the mean unless it is zero, one quotient bit per cycle.
// The result register frees the input: a new item is taken while a result waits;
// the controller holds in its final state only while an older result is unread.
// Reset is immediate; the interval ring holds no data until written.
module adaptive_peak_pulse_rate_meter_unit
  import appm_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  appm_in_if.sink               smp_i,
  appm_out_if.source            res_o
);

  appm_cmd_t  cmd;
  appm_stat_t stat;

  appm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  appm_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (smp_i.sample),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pulse_found_o (res_o.pulse_found),
    .rate_bpm_o    (res_o.rate_bpm),
    .pulse_total_o (res_o.pulse_total)
  );

endmodule

### design/appm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module appm_div #(
  parameter int unsigned W = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W:0]    trial;

  always_comb begin
    trial = {rem_q, quot_q[W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d  = W'(trial - {1'b0, dvs_q});
      quot_d = {quot_q[W-2:0], 1'b1};
    end else begin
      rem_d  = trial[W-1:0];
      quot_d = {quot_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

### design/appm_dp.sv
// Datapath: config registers, peak tracking, thresholds, interval ring and rate.
module appm_dp
  import appm_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  appm_cmd_t                     cmd_i,
  output appm_stat_t                    stat_o,
  output logic                          pulse_found_o,
  output logic [RATE_W-1:0]             rate_bpm_o,
  output logic [CNT_W-1:0]              pulse_total_o
);

  localparam int unsigned PF = PEAK_W - SAMPLE_BITS;
  localparam int unsigned CW = (FLOOR_W + PF > PEAK_W) ? FLOOR_W + PF : PEAK_W;
  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  // configuration
  logic [FLOOR_W-1:0] thr_floor_q;
  logic [CNT_W-1:0]   min_iv_q, max_iv_q, timeout_q, period_len_q;

  // item state
  logic [PEAK_W-1:0]  peak_q;
  logic               above_q;
  logic [CNT_W-1:0]   ticks_q;
  logic [CNT_W-1:0]   period_q;
  logic [PW-1:0]      pos_q;
  logic [FW-1:0]      fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic [RATE_W-1:0]  rate_q;
  logic [CNT_W-1:0]   count_q;
  logic               found_q;
  logic               store_q;

  // payload
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [PROD_W-1:0]  prod_q;
  logic [CW-1:0]      upper_q, lower_q;
  logic [CNT_W-1:0]   iv_q;
  logic [CNT_W-1:0]   ring_q [RING_DEPTH];
  logic               out_found_q;
  logic [RATE_W-1:0]  out_rate_q;
  logic [CNT_W-1:0]   out_count_q;

  logic [PEAK_W:0]    s33;
  logic [PEAK_W-1:0]  peak_max;
  logic [PEAK_W-1:0]  peak_new;
  logic [PEAK_W+1:0]  up_sum;
  logic [CW-1:0]      upper_raw, lower_raw, floor_cmp, s_cmp;
  logic               ge_upper, le_lower, found, in_window;
  logic               ring_full;
  logic [SUM_W-1:0]   div_a, div_b, div_q;
  logic               div_done;

  // sample scaled to the peak's fraction bits, sign-extended by one bit
  assign s33 = {sample_q[SAMPLE_BITS-1], sample_q, {PF{1'b0}}};
  assign peak_max = ($signed(s33) > $signed({1'b0, peak_q})) ? s33[PEAK_W-1:0] : peak_q;

  assign peak_new  = prod_q[PROD_W-1:DECAY_W];
  assign up_sum    = {2'b00, peak_new} + {1'b0, peak_new, 1'b0};
  assign upper_raw = CW'(up_sum[PEAK_W+1:2]);
  assign lower_raw = CW'(peak_new[PEAK_W-1:1]);
  assign floor_cmp = CW'({thr_floor_q, {PF{1'b0}}});

  assign s_cmp     = CW'(s33[PEAK_W-1:0]);
  assign ge_upper  = !s33[PEAK_W] && (s_cmp >= upper_q);
  assign le_lower  = s33[PEAK_W] || (s33 == '0) || (s_cmp <= lower_q);
  assign found     = ge_upper && !above_q;
  assign in_window = (ticks_q > min_iv_q) && (ticks_q < max_iv_q);
  assign ring_full = (fill_q == FW'(RING_DEPTH));

  assign div_a = cmd_i.div_second ? RATE_NUM : sum_q;
  assign div_b = cmd_i.div_second ? div_q : SUM_W'(fill_q);

  appm_div #(
    .W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign stat_o.report_due = (period_q >= period_len_q);
  assign stat_o.ring_empty = (fill_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.div_zero   = (div_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_floor_q  <= FLOOR_RST;
      min_iv_q     <= MIN_IV_RST;
      max_iv_q     <= MAX_IV_RST;
      timeout_q    <= TIMEOUT_RST;
      period_len_q <= PERIOD_RST;
      peak_q       <= '0;
      above_q      <= 1'b0;
      ticks_q      <= '0;
      period_q     <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      rate_q       <= RATE_RST;
      count_q      <= '0;
      found_q      <= 1'b0;
      store_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FLOOR:   thr_floor_q  <= cfg_data_i[FLOOR_W-1:0];
          CFG_MIN_IV:  min_iv_q     <= cfg_data_i;
          CFG_MAX_IV:  max_iv_q     <= cfg_data_i;
          CFG_TIMEOUT: timeout_q    <= cfg_data_i;
          CFG_PERIOD:  period_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && (ticks_q != '1)) begin
        ticks_q <= ticks_q + 1'b1;
      end
      if (cmd_i.thr) begin
        peak_q <= peak_new;
      end
      if (cmd_i.cmp) begin
        found_q <= found;
        store_q <= found && in_window;
        // a sample at or below the lower threshold clears the flag even on a pulse
        above_q <= le_lower ? 1'b0 : (found ? 1'b1 : above_q);
        if (found) begin
          count_q <= count_q + 1'b1;
          ticks_q <= '0;
        end
      end
      if (cmd_i.store) begin
        if (store_q) begin
          if (ring_full) begin
            sum_q <= sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(iv_q);
          end else begin
            sum_q  <= sum_q + SUM_W'(iv_q);
            fill_q <= fill_q + 1'b1;
          end
          pos_q <= (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        end
        if (ticks_q > timeout_q) begin
          rate_q <= '0;
        end
        if (period_q != '1) begin
          period_q <= period_q + 1'b1;
        end
      end
      if (cmd_i.period_clr) begin
        period_q <= '0;
      end
      if (cmd_i.rate_zero) begin
        rate_q <= '0;
      end else if (cmd_i.rate_div) begin
        rate_q <= (div_q > SUM_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(peak_max) * PROD_W'(DECAY_NUM);
    end
    if (cmd_i.thr) begin
      // lift both thresholds to the floor when the upper one is not above it
      if (upper_raw <= floor_cmp) begin
        upper_q <= floor_cmp;
        lower_q <= floor_cmp;
      end else begin
        upper_q <= upper_raw;
        lower_q <= lower_raw;
      end
    end
    if (cmd_i.cmp && found) begin
      iv_q <= ticks_q;
    end
    if (cmd_i.store && store_q) begin
      ring_q[pos_q] <= iv_q;
    end
    if (cmd_i.out_load) begin
      out_found_q <= found_q;
      out_rate_q  <= rate_q;
      out_count_q <= count_q;
    end
  end

  assign pulse_found_o = out_found_q;
  assign rate_bpm_o    = out_rate_q;
  assign pulse_total_o = out_count_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FW'(RING_DEPTH)) && (pos_q <= PW'(RING_DEPTH - 1)))
    else $error("ring fill or write position out of range");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store && store_q && !ring_full |=> fill_q == $past(fill_q) + 1'b1)
    else $error("ring fill did not advance on store");

  a_pulse_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp && found |=> found_q && ticks_q == '0)
    else $error("pulse not recorded");

endmodule

### design/appm_ctrl.sv
// Controller: sequences one item through the datapath and holds output valid.
module appm_ctrl
  import appm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  appm_stat_t stat_i,
  output appm_cmd_t  cmd_o
);

  appm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_THR;
      end
      ST_THR: begin
        cmd_o.thr = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_PER;
      end
      ST_PER: begin
        state_d = ST_DONE;
        if (stat_i.report_due) begin
          cmd_o.period_clr = 1'b1;
          if (stat_i.ring_empty) begin
            cmd_o.rate_zero = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        // mean interval ready; a zero mean reads as no rate
        if (stat_i.div_done) begin
          if (stat_i.div_zero) begin
            cmd_o.rate_zero = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.div_start  = 1'b1;
            cmd_o.div_second = 1'b1;
            state_d          = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (stat_i.div_done) begin
          cmd_o.rate_div = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded but not shown");

  a_done_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !out_free |=> (state_q == ST_DONE))
    else $error("result dropped while output stalled");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == ST_DIV1) || (state_q == ST_DIV2))
    else $error("divider started outside report sequence");

endmodule

### tb/sv/tb_adaptive_peak_pulse_rate_meter_unit.sv
// Self-checking testbench for the adaptive peak pulse rate meter: sample driver, result monitor.
module tb_adaptive_peak_pulse_rate_meter_unit;
  import appm_pkg::*;

  localparam int unsigned RING_DEPTH  = 10;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned PEAK_FRAC   = PEAK_W - SAMPLE_BITS;
  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 64;
  localparam int unsigned LOG_CAP     = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic              pulse_found;
    logic [RATE_W-1:0] rate_bpm;
    logic [CNT_W-1:0]  pulse_total;
  } meter_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  appm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_bus ();
  appm_out_if                             res_bus ();

  adaptive_peak_pulse_rate_meter_unit #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .smp_i     (smp_bus),
    .res_o     (res_bus)
  );

  // register mirror
  logic [FLOOR_W-1:0] m_floor;
  logic [CNT_W-1:0]   m_min_iv;
  logic [CNT_W-1:0]   m_max_iv;
  logic [CNT_W-1:0]   m_timeout;
  logic [CNT_W-1:0]   m_period;

  // meter state mirror
  logic [PEAK_W-1:0]  peak_q;
  logic               above_q;
  logic [CNT_W-1:0]   since_pulse;
  logic [CNT_W-1:0]   iv_ring [RING_DEPTH];
  int unsigned        ring_pos;
  int unsigned        ring_cnt;
  logic [SUM_W-1:0]   iv_sum;
  logic [CNT_W-1:0]   period_cnt;
  logic [RATE_W-1:0]  rate_q;
  logic [CNT_W-1:0]   beat_cnt;

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  meter_result_t                 predicted_readings [$];
  meter_result_t                 next_reading;
  meter_result_t                 want;
  int unsigned                   in_wait;
  int unsigned                   out_wait;
  int unsigned                   out_hold;
  int unsigned                   stall_cycles;
  int unsigned                   err_count;
  bit                            calm;

  task automatic advance_meter(input logic signed [SAMPLE_BITS-1:0] smp,
                               output meter_result_t res);
    longint      scaled;
    logic [63:0] prod;
    logic [63:0] upper;
    logic [63:0] lower;
    logic [63:0] floor_q;
    logic [CNT_W-1:0] iv;
    logic        found;
    int unsigned mean;
    int unsigned bpm;
    found  = 1'b0;
    scaled = longint'(smp) * (longint'(1) << PEAK_FRAC);
    if (since_pulse != '1) since_pulse++;

    if (scaled > longint'(peak_q)) peak_q = scaled[PEAK_W-1:0];
    prod   = 64'(peak_q) * 64'(DECAY_NUM);
    peak_q = prod[PEAK_W+DECAY_W-1:DECAY_W];

    upper   = (64'(peak_q) * 3) >> 2;
    lower   = 64'(peak_q) >> 1;
    floor_q = 64'(m_floor) << PEAK_FRAC;
    if (upper <= floor_q) begin
      upper = floor_q;
      lower = floor_q;
    end

    // hysteresis: count only a fresh crossing of the upper threshold
    if (scaled >= 0 && $unsigned(scaled) >= upper && !above_q) begin
      above_q  = 1'b1;
      beat_cnt = beat_cnt + 1'b1;
      found    = 1'b1;
    end
    if (scaled <= 0 || $unsigned(scaled) <= lower) above_q = 1'b0;

    if (found) begin
      iv          = since_pulse;
      since_pulse = '0;
      if (iv > m_min_iv && iv < m_max_iv) begin
        // drop the oldest interval once the ring is full
        if (ring_cnt >= RING_DEPTH) iv_sum = iv_sum - iv_ring[ring_pos];
        else ring_cnt++;
        iv_ring[ring_pos] = iv;
        iv_sum            = iv_sum + iv;
        ring_pos          = (ring_pos + 1 >= RING_DEPTH) ? 0 : ring_pos + 1;
      end
    end

    if (since_pulse > m_timeout) rate_q = '0;

    if (period_cnt != '1) period_cnt++;
    if (period_cnt >= m_period) begin
      period_cnt = '0;
      mean       = (ring_cnt == 0) ? 0 : iv_sum / ring_cnt;
      if (mean == 0) begin
        rate_q = '0;
      end else begin
        bpm    = RATE_NUM / mean;
        rate_q = (bpm > RATE_MAX) ? RATE_MAX : RATE_W'(bpm);
      end
    end

    res = '{pulse_found: found, rate_bpm: rate_q, pulse_total: beat_cnt};
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_v);
    // cap the log, keep counting
    if (err_count < LOG_CAP)
      $display("%0t %s: got %0d, predicted %0d", $time, what, got, exp_v);
    err_count++;
  endtask

  task automatic push_sample(input int v);
    pending_samples.push_back(SAMPLE_BITS'(v));
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_sample($urandom);
  endtask

  // beats: rise, peak, fall, then a noisy baseline with an occasional stray bump
  task automatic push_beats(input int n, input int iv_lo, input int iv_hi);
    int amp;
    int len;
    int v;
    repeat (n) begin
      amp = $urandom_range(100, 32767);
      len = $urandom_range(iv_lo, iv_hi);
      push_sample(amp / 2);
      push_sample(amp);
      push_sample(amp * 3 / 4);
      for (int k = 3; k < len; k++) begin
        if ($urandom_range(0, 15) == 0) v = $urandom_range(0, amp);
        else v = int'($urandom_range(0, amp / 4)) - amp / 8;
        push_sample(v);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FLOOR:   m_floor   = val[FLOOR_W-1:0];
      CFG_MIN_IV:  m_min_iv  = val;
      CFG_MAX_IV:  m_max_iv  = val;
      CFG_TIMEOUT: m_timeout = val;
      CFG_PERIOD:  m_period  = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input int unsigned floor_v, input int unsigned min_v,
                               input int unsigned max_v, input int unsigned tmo_v,
                               input int unsigned per_v);
    // the spare top bit of the floor must be ignored
    write_reg(CFG_FLOOR, CFG_DATA_W'(floor_v) | CFG_DATA_W'($urandom_range(0, 1) << FLOOR_W));
    write_reg(CFG_MIN_IV, CFG_DATA_W'(min_v));
    write_reg(CFG_MAX_IV, CFG_DATA_W'(max_v));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo_v));
    write_reg(CFG_PERIOD, CFG_DATA_W'(per_v));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || smp_bus.valid || predicted_readings.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_bus.valid  <= 1'b0;
      smp_bus.sample <= '0;
      in_wait        <= 0;
    end else begin
      if (smp_bus.valid && smp_bus.ready) begin
        advance_meter(smp_bus.sample, next_reading);
        predicted_readings.push_back(next_reading);
      end
      if (!smp_bus.valid || smp_bus.ready) begin
        if (in_wait != 0) begin
          in_wait       <= in_wait - 1;
          smp_bus.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          smp_bus.sample <= pending_samples.pop_front();
          smp_bus.valid  <= 1'b1;
          in_wait        <= calm ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          smp_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      out_wait      <= 0;
    end else if (res_bus.valid && res_bus.ready) begin
      if (predicted_readings.size() == 0) begin
        report_mismatch("result with nothing predicted, pulse_total", res_bus.pulse_total, 0);
      end else begin
        want = predicted_readings.pop_front();
        if (res_bus.pulse_found !== want.pulse_found)
          report_mismatch("pulse_found", res_bus.pulse_found, want.pulse_found);
        if (res_bus.rate_bpm !== want.rate_bpm)
          report_mismatch("rate_bpm", res_bus.rate_bpm, want.rate_bpm);
        if (res_bus.pulse_total !== want.pulse_total)
          report_mismatch("pulse_total", res_bus.pulse_total, want.pulse_total);
      end
      out_hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      out_wait      <= out_hold;
      res_bus.ready <= (out_hold == 0);
    end else if (out_wait != 0) begin
      out_wait      <= out_wait - 1;
      res_bus.ready <= (out_wait == 1);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_adaptive_peak_pulse_rate_meter_unit: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int edge_a [16];
    int edge_b [6];
    int edge_c [4];
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_FLOOR;
    cfg_data     = '0;
    calm         = 1'b0;
    err_count    = 0;
    m_floor      = FLOOR_RST;
    m_min_iv     = MIN_IV_RST;
    m_max_iv     = MAX_IV_RST;
    m_timeout    = TIMEOUT_RST;
    m_period     = PERIOD_RST;
    peak_q       = '0;
    above_q      = 1'b0;
    since_pulse  = '0;
    ring_pos     = 0;
    ring_cnt     = 0;
    iv_sum       = '0;
    period_cnt   = '0;
    rate_q       = RATE_RST;
    beat_cnt     = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: floor lift, hysteresis, sign and magnitude extremes
    edge_a = '{0, 200, 300, 301, 300, 400, 1, 32767, 32767, 20000, 32767, -32768, 32767,
               -1, 1, -32767};
    foreach (edge_a[i]) push_sample(edge_a[i]);
    wait_idle();

    // zero floor, open window, zero timeout, report on every tick from an empty ring
    set_registers(0, 0, 65535, 0, 0);
    edge_b = '{0, -5, 32767, 1, 32767, 5};
    foreach (edge_b[i]) push_sample(edge_b[i]);
    wait_idle();

    // top floor, closed window
    set_registers(32767, 65535, 0, 65535, 1);
    edge_c = '{32767, 32766, 32767, -32768};
    foreach (edge_c[i]) push_sample(edge_c[i]);
    wait_idle();

    set_registers($urandom_range(0, 2000), $urandom_range(2, 10), $urandom_range(30, 80),
                  $urandom_range(20, 90), $urandom_range(1, 60));
    calm = ($urandom_range(0, 3) == 0);
    push_beats(10, 5, 50);
    push_noise(10);
    wait_idle();

    set_registers(0, $urandom_range(1, 4), $urandom_range(15, 40), $urandom_range(5, 30),
                  $urandom_range(1, 5));
    calm = 1'b0;
    push_noise(20);
    push_beats(10, 3, 30);
    push_noise(20);
    wait_idle();

    // long intervals so the mean lands below the rate ceiling
    set_registers(300, 235, 400, 380, $urandom_range(150, 400));
    calm = ($urandom_range(0, 1) == 0);
    push_beats(2, 236, 260);
    wait_idle();

    set_registers(32767, 65535, 0, 65535, 65535);
    calm = 1'b0;
    push_beats(3, 5, 20);
    push_noise(30);
    push_sample(32767);
    wait_idle();

    set_registers($urandom_range(0, 32767), $urandom_range(0, 20), $urandom_range(20, 65535),
                  $urandom_range(0, 65535), $urandom_range(1, 65535));
    calm = ($urandom_range(0, 3) == 0);
    push_beats(4, 4, 40);
    push_noise(20);
    wait_idle();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_adaptive_peak_pulse_rate_meter_unit: done, clean");
    end else begin
      $display("tb_adaptive_peak_pulse_rate_meter_unit: done, errors");
    end
    $finish;
  end

endmodule
